FILE: hw/rtl/lpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpr_pkg;

  // Default sizes of the frame table.
  localparam int unsigned MaxFramesDefault = 8;
  localparam int unsigned PageBitsDefault  = 16;
  localparam int unsigned StampBitsDefault = 32;

  // Fixed widths of the payload and of the register.
  localparam int unsigned PageInW   = 16;
  localparam int unsigned FrameOutW = 3;
  localparam int unsigned CountW    = 32;
  localparam int unsigned FramesW   = 4;

  // Configuration port.
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgAddrW-1:0] AddrFramesInUse = 3'd0;
  localparam logic [FramesW-1:0]  FramesInUseReset = 4'd8;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;  // start of a new reference, drop the previous scan
    logic beat;   // a frame's read data is valid this cycle
  } scan_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lpr_frame_table.sv
`timescale 1ns / 1ps
`default_nettype none

module lpr_frame_table #(
  parameter int unsigned MAX_FRAMES = lpr_pkg::MaxFramesDefault,
  parameter int unsigned PAGE_BITS  = lpr_pkg::PageBitsDefault,
  parameter int unsigned STAMP_BITS = lpr_pkg::StampBitsDefault,
  localparam int unsigned IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_en_i,
  input  logic [IdxW-1:0]       rd_addr_i,
  input  logic                  wr_en_i,
  input  logic                  wr_page_en_i,
  input  logic [IdxW-1:0]       wr_addr_i,
  input  logic [PAGE_BITS-1:0]  wr_page_i,
  input  logic [STAMP_BITS-1:0] wr_stamp_i,
  input  logic                  clear_all_i,
  output logic                  rd_beat_o,
  output logic [IdxW-1:0]       rd_idx_o,
  output logic [PAGE_BITS-1:0]  rd_page_o,
  output logic [STAMP_BITS-1:0] rd_stamp_o,
  output logic                  rd_valid_o
);

  logic [PAGE_BITS-1:0]  page_mem [MAX_FRAMES];
  logic [STAMP_BITS-1:0] stamp_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_q;
  logic                  rd_beat_q;
  logic [IdxW-1:0]       rd_idx_q;
  logic [PAGE_BITS-1:0]  rd_page_q;
  logic [STAMP_BITS-1:0] rd_stamp_q;

  // Page and stamp storage, one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      stamp_mem[wr_addr_i] <= wr_stamp_i;
      if (wr_page_en_i) begin
        page_mem[wr_addr_i] <= wr_page_i;
      end
    end
    if (rd_en_i) begin
      rd_page_q  <= page_mem[rd_addr_i];
      rd_stamp_q <= stamp_mem[rd_addr_i];
    end
  end

  // Read beat tracking and the valid bits; a clear empties the whole table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rd_beat_q <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      rd_beat_q <= rd_en_i;
      if (rd_en_i) begin
        rd_idx_q <= rd_addr_i;
      end
      if (clear_all_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
    end
  end

  assign rd_beat_o  = rd_beat_q;
  assign rd_idx_o   = rd_idx_q;
  assign rd_page_o  = rd_page_q;
  assign rd_stamp_o = rd_stamp_q;
  assign rd_valid_o = valid_q[rd_idx_q];

endmodule

`default_nettype wire

FILE: hw/rtl/lpr_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module lpr_scan #(
  parameter int unsigned MAX_FRAMES = lpr_pkg::MaxFramesDefault,
  parameter int unsigned PAGE_BITS  = lpr_pkg::PageBitsDefault,
  parameter int unsigned STAMP_BITS = lpr_pkg::StampBitsDefault,
  localparam int unsigned IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lpr_pkg::scan_ctrl_t   ctrl_i,
  input  logic [IdxW-1:0]       idx_i,
  input  logic [PAGE_BITS-1:0]  page_i,
  input  logic [STAMP_BITS-1:0] stamp_i,
  input  logic                  valid_i,
  input  logic [PAGE_BITS-1:0]  target_i,
  output logic                  hit_o,
  output logic [IdxW-1:0]       slot_o
);

  logic                  hit_q;
  logic [IdxW-1:0]       hit_idx_q;
  logic                  empty_q;
  logic [IdxW-1:0]       empty_idx_q;
  logic                  seen_q;
  logic [IdxW-1:0]       old_idx_q;
  logic [STAMP_BITS-1:0] old_stamp_q;

  // One frame per beat: first match, first empty frame, and the oldest stamp
  // (strictly smaller wins, so ties keep the lowest frame).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      empty_q <= 1'b0;
      seen_q  <= 1'b0;
    end else if (ctrl_i.clear) begin
      hit_q   <= 1'b0;
      empty_q <= 1'b0;
      seen_q  <= 1'b0;
    end else if (ctrl_i.beat) begin
      seen_q <= 1'b1;
      if (!hit_q && valid_i && (page_i == target_i)) begin
        hit_q <= 1'b1;
      end
      if (!empty_q && !valid_i) begin
        empty_q <= 1'b1;
      end
    end
  end

  // Index and stamp payload of the accumulators.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.beat && !ctrl_i.clear) begin
      if (!hit_q && valid_i && (page_i == target_i)) begin
        hit_idx_q <= idx_i;
      end
      if (!empty_q && !valid_i) begin
        empty_idx_q <= idx_i;
      end
      if (!seen_q || (stamp_i < old_stamp_q)) begin
        old_idx_q   <= idx_i;
        old_stamp_q <= stamp_i;
      end
    end
  end

  // Victim choice: a hit frame first, then an empty one, then the oldest.
  always_comb begin
    hit_o = hit_q;
    if (hit_q) begin
      slot_o = hit_idx_q;
    end else if (empty_q) begin
      slot_o = empty_idx_q;
    end else begin
      slot_o = old_idx_q;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lru_page_replacement_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// LRU page replacement over a fully associative table of MAX_FRAMES frames,
// of which the first frames_in_use take part. A reference is taken when start
// is high while busy is low; the frames are then read one per cycle through a
// single memory read port and a single compare unit, so busy stays high through
// the scan of the active frames (1 to MAX_FRAMES), a drain state and a write
// state. The result beat appears in the cycle in which busy falls, marked by
// done_o for exactly one cycle; it cannot be stalled and must be captured then.
// A new reference may be started in that same cycle. After a reference marked
// last, the table, the time and the fault count clear.
// frames_in_use should only be written while the block is idle.
module lru_page_replacement_unit #(
  parameter int unsigned MAX_FRAMES = lpr_pkg::MaxFramesDefault,
  parameter int unsigned PAGE_BITS  = lpr_pkg::PageBitsDefault,
  parameter int unsigned STAMP_BITS = lpr_pkg::StampBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Reference channel
  input  logic                            start,
  output logic                            busy,
  input  logic [lpr_pkg::PageInW-1:0]     page_number_i,
  input  logic                            last_reference_i,
  // Result channel
  output logic                            done_o,
  output logic                            hit_o,
  output logic [lpr_pkg::FrameOutW-1:0]   frame_index_o,
  output logic [lpr_pkg::CountW-1:0]      fault_count_o,
  output logic                            is_last_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpr_pkg::CfgAddrW-1:0]    paddr,
  input  logic [lpr_pkg::CfgDataW-1:0]    pwdata,
  output logic [lpr_pkg::CfgDataW-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned IdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CntW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [lpr_pkg::FramesW-1:0]   frames_q;
  logic [CntW-1:0]               limit;
  logic [CntW-1:0]               limit_q;
  logic [IdxW-1:0]               addr_q;
  logic [PAGE_BITS-1:0]          page_q;
  logic                          last_q;
  logic [STAMP_BITS-1:0]         time_q;
  logic [lpr_pkg::CountW-1:0]    faults_q;
  logic [lpr_pkg::CountW-1:0]    faults_next;
  logic                          accept;
  logic                          last_addr;
  logic                          cfg_write;
  lpr_pkg::scan_ctrl_t           scan_ctrl;

  logic                          rd_beat;
  logic [IdxW-1:0]               rd_idx;
  logic [PAGE_BITS-1:0]          rd_page;
  logic [STAMP_BITS-1:0]         rd_stamp;
  logic                          rd_valid;
  logic                          scan_hit;
  logic [IdxW-1:0]               scan_slot;

  logic                          done_q;
  logic                          hit_q;
  logic [lpr_pkg::FrameOutW-1:0] frame_q;
  logic [lpr_pkg::CountW-1:0]    count_q;
  logic                          is_last_q;

  // Configuration register.
  assign cfg_write = psel && penable && pwrite && (paddr == lpr_pkg::AddrFramesInUse);
  assign pready    = 1'b1;
  assign prdata    = (paddr == lpr_pkg::AddrFramesInUse) ?
                     lpr_pkg::CfgDataW'(frames_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= lpr_pkg::FramesInUseReset;
    end else if (cfg_write) begin
      frames_q <= pwdata[lpr_pkg::FramesW-1:0];
    end
  end

  // Active frame count: zero acts as one, large values clamp to the table.
  always_comb begin
    if (frames_q == '0) begin
      limit = CntW'(1);
    end else if (32'(frames_q) > MAX_FRAMES) begin
      limit = CntW'(MAX_FRAMES);
    end else begin
      limit = CntW'(frames_q);
    end
  end

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign last_addr = (CntW'(addr_q) == (limit_q - CntW'(1)));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_SCAN;
      S_SCAN:  if (last_addr) state_d = S_DRAIN;
      S_DRAIN: state_d = S_WRITE;
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      addr_q  <= '0;
      limit_q <= CntW'(1);
    end else begin
      state_q <= state_d;
      if (accept) begin
        addr_q  <= '0;
        limit_q <= limit;
      end else if ((state_q == S_SCAN) && !last_addr) begin
        addr_q <= addr_q + IdxW'(1);
      end
    end
  end

  // Reference payload held for the duration of the scan.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= PAGE_BITS'(page_number_i);
      last_q <= last_reference_i;
    end
  end

  assign scan_ctrl.clear = accept;
  assign scan_ctrl.beat  = rd_beat;

  lpr_frame_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (state_q == S_SCAN),
    .rd_addr_i    (addr_q),
    .wr_en_i      (state_q == S_WRITE),
    .wr_page_en_i (!scan_hit),
    .wr_addr_i    (scan_slot),
    .wr_page_i    (page_q),
    .wr_stamp_i   (time_q),
    .clear_all_i  ((state_q == S_WRITE) && last_q),
    .rd_beat_o    (rd_beat),
    .rd_idx_o     (rd_idx),
    .rd_page_o    (rd_page),
    .rd_stamp_o   (rd_stamp),
    .rd_valid_o   (rd_valid)
  );

  lpr_scan #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (scan_ctrl),
    .idx_i    (rd_idx),
    .page_i   (rd_page),
    .stamp_i  (rd_stamp),
    .valid_i  (rd_valid),
    .target_i (page_q),
    .hit_o    (scan_hit),
    .slot_o   (scan_slot)
  );

  // Saturating fault count, including this reference.
  assign faults_next = (!scan_hit && (faults_q != '1)) ?
                       faults_q + lpr_pkg::CountW'(1) : faults_q;

  // Time and fault count; both clear after the last reference of a string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      faults_q <= '0;
    end else if (state_q == S_WRITE) begin
      if (last_q) begin
        time_q   <= '0;
        faults_q <= '0;
      end else begin
        faults_q <= faults_next;
        if (time_q != '1) begin
          time_q <= time_q + STAMP_BITS'(1);
        end
      end
    end
  end

  // Result beat, shown for one cycle after the table update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_WRITE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      hit_q     <= scan_hit;
      frame_q   <= lpr_pkg::FrameOutW'(scan_slot);
      count_q   <= faults_next;
      is_last_q <= last_q;
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign frame_index_o = frame_q;
  assign fault_count_o = count_q;
  assign is_last_o     = is_last_q;

endmodule

`default_nettype wire
